FILE: sv/sfq_pkg.sv
package sfq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2
    } sfq_op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] net_index;
        logic        fault_kind;
        logic [15:0] detect_count;
        logic        already_detected;
        logic        under_test;
    } sfq_cmd_t;

    typedef struct packed {
        logic        pop_valid;
        logic [15:0] out_net_index;
        logic        out_fault_kind;
        logic [15:0] out_detect_count;
        logic        inserted;
        logic        overflow;
        logic [6:0]  occupancy;
        logic        nonempty;
    } sfq_result_t;

    // One queue entry as it moves along the chain.
    typedef struct packed {
        logic        valid;
        logic [15:0] net;
        logic        ftype;
        logic [15:0] count;
    } sfq_entry_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic        insert;
        logic        pop;
        logic        clear;
        logic [15:0] key;
    } sfq_ctrl_t;

endpackage

FILE: sv/sfq_cell.sv
module sfq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sfq_pkg::sfq_ctrl_t ctrl,
    input  sfq_pkg::sfq_entry_t new_entry,
    input  sfq_pkg::sfq_entry_t left_entry,
    input  logic               left_keep,
    input  sfq_pkg::sfq_entry_t right_entry,
    output sfq_pkg::sfq_entry_t entry,
    output logic               keep
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] net_reg;
    logic [15:0] net_next;
    logic        ftype_reg;
    logic        ftype_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;

    // A held entry with a count not above the new key stays put, so equal
    // keys keep their arrival order.
    assign keep = valid_reg && (count_reg <= ctrl.key);

    assign entry.valid = valid_reg;
    assign entry.net   = net_reg;
    assign entry.ftype = ftype_reg;
    assign entry.count = count_reg;

    always_comb
    begin
        valid_next = valid_reg;
        net_next   = net_reg;
        ftype_next = ftype_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_next = right_entry.valid;
            net_next   = right_entry.net;
            ftype_next = right_entry.ftype;
            count_next = right_entry.count;
        end
        else if (ctrl.insert && !keep)
        begin
            if (left_keep)
            begin
                valid_next = new_entry.valid;
                net_next   = new_entry.net;
                ftype_next = new_entry.ftype;
                count_next = new_entry.count;
            end
            else
            begin
                valid_next = left_entry.valid;
                net_next   = left_entry.net;
                ftype_next = left_entry.ftype;
                count_next = left_entry.count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        net_reg   <= net_next;
        ftype_reg <= ftype_next;
        count_reg <= count_next;
    end

endmodule

FILE: sv/stable_sorted_fault_queue_top.sv
// The result of a transaction is registered: it appears on result with done high in the
// cycle after start is taken. Throughput: one transaction per cycle; busy stays low, as
// every cell of the chain compares and shifts at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties the queue at once and clears the result strobe.
module stable_sorted_fault_queue_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sfq_pkg::sfq_cmd_t    cmd,
    output logic                 done,
    output sfq_pkg::sfq_result_t result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    sfq_pkg::sfq_ctrl_t   ctrl;
    sfq_pkg::sfq_entry_t  new_entry;
    sfq_pkg::sfq_entry_t  empty_entry;
    sfq_pkg::sfq_entry_t  cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 done_reg;
    logic                 done_next;
    sfq_pkg::sfq_result_t result_reg;
    sfq_pkg::sfq_result_t result_next;

    logic is_insert;
    logic is_pop;
    logic is_clear;
    logic qualifies;
    logic full;
    logic do_insert;
    logic do_pop;

    assign busy = 1'b0;

    assign is_insert = start && (cmd.operation == sfq_pkg::OP_INSERT);
    assign is_pop    = start && (cmd.operation == sfq_pkg::OP_POP);
    assign is_clear  = start && (cmd.operation == sfq_pkg::OP_CLEAR);
    assign qualifies = !cmd.already_detected && cmd.under_test && (cmd.detect_count != 16'd0);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign do_insert = is_insert && qualifies && !full;
    assign do_pop    = is_pop && cell_entry[0].valid;

    assign ctrl.insert = do_insert;
    assign ctrl.pop    = do_pop;
    assign ctrl.clear  = is_clear;
    assign ctrl.key    = cmd.detect_count;

    assign new_entry.valid = 1'b1;
    assign new_entry.net   = cmd.net_index;
    assign new_entry.ftype = cmd.fault_kind;
    assign new_entry.count = cmd.detect_count;

    assign empty_entry = '0;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            sfq_pkg::sfq_entry_t left_entry;
            sfq_pkg::sfq_entry_t right_entry;
            logic                left_keep;

            if (g == 0)
            begin : g_head
                assign left_entry = new_entry;
                assign left_keep  = 1'b0;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[g-1];
                assign left_keep  = cell_keep[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = empty_entry;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[g+1];
            end

            sfq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .entry       (cell_entry[g]),
                .keep        (cell_keep[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (is_clear)
        begin
            count_next = '0;
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (do_insert)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        done_next                    = start;
        result_next                  = '0;
        result_next.pop_valid        = do_pop;
        result_next.inserted         = do_insert;
        result_next.overflow         = is_insert && qualifies && full;
        result_next.occupancy        = 7'(count_next);
        result_next.nonempty         = (count_next != '0);
        if (do_pop)
        begin
            result_next.out_net_index    = cell_entry[0].net;
            result_next.out_fault_kind   = cell_entry[0].ftype;
            result_next.out_detect_count = cell_entry[0].count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sim/sfq_checker.sv
`timescale 1ns / 1ps

module sfq_checker #(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  sfq_pkg::sfq_cmd_t    cmd,
    input  logic                 done,
    input  sfq_pkg::sfq_result_t result,
    output int                   errors,
    output int                   pending
);

    // Own copy of the sorted queue; slot 0 is the head.
    logic [15:0] held_net   [DEPTH];
    logic        held_type  [DEPTH];
    logic [15:0] held_count [DEPTH];
    int          held;

    sfq_pkg::sfq_result_t expected_results [$];
    sfq_pkg::sfq_result_t want;
    int                   mismatches;
    logic                 bad;

    task automatic apply_command(input sfq_pkg::sfq_cmd_t c,
                                 output sfq_pkg::sfq_result_t r);
        int pos;
        int i;
        r = '0;
        case (c.operation)
            sfq_pkg::OP_INSERT:
            begin
                if (!c.already_detected && c.under_test && c.detect_count != 16'd0)
                begin
                    if (held >= DEPTH)
                    begin
                        r.overflow = 1'b1;
                    end
                    else
                    begin
                        // New entry goes behind every equal key to keep order stable.
                        pos = 0;
                        while (pos < held && held_count[pos] <= c.detect_count)
                            pos++;
                        for (i = held; i > pos; i--)
                        begin
                            held_net[i]   = held_net[i - 1];
                            held_type[i]  = held_type[i - 1];
                            held_count[i] = held_count[i - 1];
                        end
                        held_net[pos]   = c.net_index;
                        held_type[pos]  = c.fault_kind;
                        held_count[pos] = c.detect_count;
                        held++;
                        r.inserted = 1'b1;
                    end
                end
            end
            sfq_pkg::OP_POP:
            begin
                if (held > 0)
                begin
                    r.pop_valid        = 1'b1;
                    r.out_net_index    = held_net[0];
                    r.out_fault_kind   = held_type[0];
                    r.out_detect_count = held_count[0];
                    for (i = 0; i + 1 < held; i++)
                    begin
                        held_net[i]   = held_net[i + 1];
                        held_type[i]  = held_type[i + 1];
                        held_count[i] = held_count[i + 1];
                    end
                    held--;
                end
            end
            sfq_pkg::OP_CLEAR:
            begin
                held = 0;
            end
            default:
            begin
            end
        endcase
        r.occupancy = 7'(held);
        r.nonempty  = (held > 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no transaction waiting: %h", $realtime,
                                 result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = (result.pop_valid !== want.pop_valid)
                        || (result.out_net_index !== want.out_net_index)
                        || (result.out_fault_kind !== want.out_fault_kind)
                        || (result.out_detect_count !== want.out_detect_count)
                        || (result.inserted !== want.inserted)
                        || (result.overflow !== want.overflow)
                        || (result.occupancy !== want.occupancy)
                        || (result.nonempty !== want.nonempty);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch", $realtime);
                            $display({"  expected pv=%b net=%h type=%b cnt=%h",
                                      " ins=%b ovf=%b occ=%0d ne=%b"},
                                     want.pop_valid, want.out_net_index, want.out_fault_kind,
                                     want.out_detect_count, want.inserted, want.overflow,
                                     want.occupancy, want.nonempty);
                            $display({"  actual   pv=%b net=%h type=%b cnt=%h",
                                      " ins=%b ovf=%b occ=%0d ne=%b"},
                                     result.pop_valid, result.out_net_index,
                                     result.out_fault_kind, result.out_detect_count,
                                     result.inserted, result.overflow, result.occupancy,
                                     result.nonempty);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                apply_command(cmd, want);
                expected_results.push_back(want);
            end
            pending <= expected_results.size();
            errors  <= mismatches;
        end
    end

endmodule

FILE: sim/stable_sorted_fault_queue_top_test.sv
`timescale 1ns / 1ps

module stable_sorted_fault_queue_top_test;

    localparam int         DEPTH          = 64;
    localparam int         RANDOM_ITEMS   = 1250;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    sfq_pkg::sfq_cmd_t    cmd;
    logic                 done;
    sfq_pkg::sfq_result_t result;
    int                   errors;
    int                   pending;
    int                   burst_left;
    int                   idle_cycles;

    stable_sorted_fault_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    sfq_checker #(
        .DEPTH(DEPTH)
    ) queue_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic sfq_pkg::sfq_cmd_t make_insert(input logic [15:0] net,
                                                      input logic ftype,
                                                      input logic [15:0] key,
                                                      input logic det,
                                                      input logic testing);
        sfq_pkg::sfq_cmd_t c;
        c.operation        = sfq_pkg::OP_INSERT;
        c.net_index        = net;
        c.fault_kind       = ftype;
        c.detect_count     = key;
        c.already_detected = det;
        c.under_test       = testing;
        return c;
    endfunction

    // Command with the given code; the other fields carry random bits.
    function automatic sfq_pkg::sfq_cmd_t make_plain(input logic [1:0] op);
        sfq_pkg::sfq_cmd_t c;
        c.operation        = op;
        c.net_index        = 16'($urandom);
        c.fault_kind       = 1'($urandom);
        c.detect_count     = 16'($urandom);
        c.already_detected = 1'($urandom);
        c.under_test       = 1'($urandom);
        return c;
    endfunction

    // Mostly small keys so that ties are frequent.
    function automatic logic [15:0] rand_key();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 16'($urandom_range(1, 6));
        else if (pick < 70)
            return 16'($urandom_range(1, 200));
        else if (pick < 85)
            return 16'($urandom);
        else if (pick < 90)
            return 16'd0;
        else if (pick < 95)
            return 16'hFFFF;
        else
            return 16'd1;
    endfunction

    function automatic sfq_pkg::sfq_cmd_t rand_insert();
        if ($urandom_range(0, 99) < 85)
            return make_insert(16'($urandom), 1'($urandom), rand_key(), 1'b0, 1'b1);
        else
            return make_insert(16'($urandom), 1'($urandom), rand_key(), 1'($urandom),
                               1'($urandom));
    endfunction

    // Sender works in bursts; a gap of random length opens each new burst.
    task automatic send(input sfq_pkg::sfq_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[stable_sorted_fault_queue_top] ERROR");
        $finish;
    end

    initial
    begin
        int                sent;
        int                mode;
        int                seg_len;
        int                roll;
        sfq_pkg::sfq_cmd_t c;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        burst_left = 0;
        sent       = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty queue, key and field extremes, filters, ties, unused code.
        send(make_plain(sfq_pkg::OP_POP));
        send(make_plain(sfq_pkg::OP_CLEAR));
        send(make_plain(OP_UNUSED));
        send(make_insert(16'h0000, 1'b0, 16'd1, 1'b0, 1'b1));
        send(make_insert(16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 1'b1));
        send(make_insert(16'h1234, 1'b0, 16'd4, 1'b1, 1'b1));
        send(make_insert(16'h2345, 1'b1, 16'd4, 1'b0, 1'b0));
        send(make_insert(16'h3456, 1'b0, 16'd0, 1'b0, 1'b1));
        send(make_insert(16'hAAAA, 1'b0, 16'd5, 1'b0, 1'b1));
        send(make_insert(16'h5555, 1'b1, 16'd5, 1'b0, 1'b1));
        send(make_insert(16'hC3C3, 1'b0, 16'd5, 1'b0, 1'b1));
        send(make_insert(16'h0F0F, 1'b1, 16'd3, 1'b0, 1'b1));
        send(make_plain(OP_UNUSED));
        send(make_plain(sfq_pkg::OP_POP));
        send(make_plain(sfq_pkg::OP_POP));
        send(make_plain(sfq_pkg::OP_POP));
        send(make_plain(sfq_pkg::OP_POP));
        send(make_plain(sfq_pkg::OP_CLEAR));
        send(make_plain(sfq_pkg::OP_POP));
        send(make_insert(16'h7777, 1'b1, 16'd7, 1'b0, 1'b1));
        send(make_plain(sfq_pkg::OP_POP));
        send(make_plain(sfq_pkg::OP_POP));

        wait_for_results();

        while (sent < RANDOM_ITEMS)
        begin
            mode    = $urandom_range(0, 9);
            seg_len = $urandom_range(20, 80);
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
            repeat (seg_len)
            begin
                roll = $urandom_range(0, 99);
                if (mode < 4)
                    c = (roll < 88) ? rand_insert() : make_plain(sfq_pkg::OP_POP);
                else if (mode < 6)
                    c = (roll < 85) ? make_plain(sfq_pkg::OP_POP) : rand_insert();
                else if (mode < 8)
                begin
                    if (roll < 48)
                        c = rand_insert();
                    else if (roll < 96)
                        c = make_plain(sfq_pkg::OP_POP);
                    else
                        c = make_plain(sfq_pkg::OP_CLEAR);
                end
                else
                begin
                    // Noise: any code, any flags, any key.
                    c = make_plain(2'($urandom));
                end
                send(c);
                sent++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("[stable_sorted_fault_queue_top] OK");
        else
            $display("[stable_sorted_fault_queue_top] ERROR");
        $finish;
    end

endmodule
